// File: design/trv_pkg.sv
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types, constants and round functions for the Trivium stream cipher.
// ----------------------------------------------------------------------------
package trv_pkg;

    localparam int STATE_BITS = 288;
    localparam int KEY_BITS   = 80;
    localparam int IV_BASE    = 93;
    localparam int ROUNDS_PER_CYCLE = 8;

    localparam logic [7:0] REQUIRED_LEN = 8'd10;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_UPPER  = 3'd0;
    localparam logic [2:0] CFG_KEY_LOWER  = 3'd1;
    localparam logic [2:0] CFG_IV_UPPER   = 3'd2;
    localparam logic [2:0] CFG_IV_LOWER   = 3'd3;
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd4;
    localparam logic [2:0] CFG_IV_LENGTH  = 3'd5;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_CRYPT = 1'b1;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_LEN_FAIL = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_in;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       status;
        logic       message_end_out;
    } t_out_item;

    typedef enum logic {
        ST_RUN,
        ST_WARM
    } t_trv_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // capture result payload of the accepted item
        logic load_state;  // load key, IV and constant bits
        logic adv8;        // advance eight rounds
        logic adv1;        // advance one round
    } t_trv_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_ok;
    } t_trv_stat;

    // One round: {keystream bit, next state}
    function automatic logic [STATE_BITS:0] trv_round(input logic [STATE_BITS-1:0] s);
        logic                  a;
        logic                  b;
        logic                  c;
        logic                  z;
        logic [STATE_BITS-1:0] nx;
        a  = s[65] ^ s[92];
        b  = s[161] ^ s[176];
        c  = s[242] ^ s[287];
        z  = a ^ b ^ c;
        a  = a ^ (s[90] & s[91]) ^ s[170];
        b  = b ^ (s[174] & s[175]) ^ s[263];
        c  = c ^ (s[285] & s[286]) ^ s[68];
        nx = {s[STATE_BITS-2:0], c};
        nx[93]  = a;
        nx[177] = b;
        return {z, nx};
    endfunction

    // Eight rounds: {keystream byte (first bit in bit 7), next state}
    function automatic logic [STATE_BITS+7:0] trv_round8(input logic [STATE_BITS-1:0] s);
        logic [STATE_BITS-1:0] st;
        logic [STATE_BITS:0]   r;
        logic [7:0]            ks;
        st = s;
        ks = '0;
        for (int p = 0; p < ROUNDS_PER_CYCLE; p++) begin
            r  = trv_round(st);
            st = r[STATE_BITS-1:0];
            ks[ROUNDS_PER_CYCLE-1-p] = r[STATE_BITS];
        end
        return {ks, st};
    endfunction

endpackage

// File: design/trv_datapath.sv
// ----------------------------------------------------------------------------
// trv_datapath
// Cipher state register, configuration registers and result payload register.
// ----------------------------------------------------------------------------
module trv_datapath
    import trv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data,
    input  t_in_item        i_in_data,
    input  t_trv_cmd        i_cmd,
    output t_trv_stat       o_stat,
    output t_out_item       o_out_data
);

    logic [15:0]           r_key_upper;
    logic [63:0]           r_key_lower;
    logic [15:0]           r_iv_upper;
    logic [63:0]           r_iv_lower;
    logic [7:0]            r_key_length;
    logic [7:0]            r_iv_length;
    logic [STATE_BITS-1:0] r_state;
    logic [STATE_BITS-1:0] n_state;
    t_out_item             r_out;
    t_out_item             n_out;

    logic [KEY_BITS-1:0]   key80;
    logic [KEY_BITS-1:0]   iv80;
    logic [STATE_BITS-1:0] load_val;
    logic [STATE_BITS:0]   step1;
    logic [STATE_BITS+7:0] step8;
    logic                  len_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper  <= '0;
            r_key_lower  <= '0;
            r_iv_upper   <= '0;
            r_iv_lower   <= '0;
            r_key_length <= REQUIRED_LEN;
            r_iv_length  <= REQUIRED_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_UPPER:  r_key_upper  <= i_cfg_data[15:0];
                CFG_KEY_LOWER:  r_key_lower  <= i_cfg_data;
                CFG_IV_UPPER:   r_iv_upper   <= i_cfg_data[15:0];
                CFG_IV_LOWER:   r_iv_lower   <= i_cfg_data;
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[7:0];
                CFG_IV_LENGTH:  r_iv_length  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign len_ok        = (r_key_length == REQUIRED_LEN) && (r_iv_length == REQUIRED_LEN);
    assign o_stat.len_ok = len_ok;

    // Load image: byte 0 bit 7 lands at the lowest position
    assign key80 = {r_key_upper, r_key_lower};
    assign iv80  = {r_iv_upper, r_iv_lower};

    always_comb begin
        load_val = '0;
        for (int p = 0; p < KEY_BITS; p++) begin
            load_val[p]           = key80[KEY_BITS-1-p];
            load_val[IV_BASE + p] = iv80[KEY_BITS-1-p];
        end
        load_val[STATE_BITS-3] = 1'b1;
        load_val[STATE_BITS-2] = 1'b1;
        load_val[STATE_BITS-1] = 1'b1;
    end

    // Round logic: eight unrolled rounds and a single round
    assign step8 = trv_round8(r_state);
    assign step1 = trv_round(r_state);

    always_comb begin
        priority if (i_cmd.load_state) begin
            n_state = load_val;
        end else if (i_cmd.adv8) begin
            n_state = step8[STATE_BITS-1:0];
        end else if (i_cmd.adv1) begin
            n_state = step1[STATE_BITS-1:0];
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // Result payload, captured on every accepted item
    always_comb begin
        n_out = r_out;
        if (i_cmd.accept) begin
            n_out.message_end_out = i_in_data.message_end;
            if (i_in_data.op == OP_CRYPT) begin
                n_out.data_out = i_in_data.data_in ^ step8[STATE_BITS+7:STATE_BITS];
                n_out.status   = STATUS_OK;
            end else begin
                n_out.data_out = '0;
                n_out.status   = len_ok ? STATUS_OK : STATUS_LEN_FAIL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

// File: design/trv_ctrl.sv
// ----------------------------------------------------------------------------
// trv_ctrl
// Handshake and warm-up sequencer for the Trivium stream cipher.
// ----------------------------------------------------------------------------
module trv_ctrl
    import trv_pkg::*;
#(
    parameter int WARMUP_ROUNDS = 1152
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_op,
    input  logic      i_out_stall,
    input  t_trv_stat i_stat,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_trv_cmd  o_cmd
);

    localparam int CW = $clog2(WARMUP_ROUNDS + 1);

    t_trv_state r_state;
    t_trv_state n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          accept;
    logic          big_step;

    assign o_in_stall  = (r_state == ST_WARM) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign big_step    = (r_cnt >= CW'(ROUNDS_PER_CYCLE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        n_out_valid      = r_out_valid;
        o_cmd.accept     = 1'b0;
        o_cmd.load_state = 1'b0;
        o_cmd.adv8       = 1'b0;
        o_cmd.adv1       = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                // result leaves when the receiver takes it
                if (r_out_valid && !i_out_stall) begin
                    n_out_valid = 1'b0;
                end
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_op == OP_CRYPT) begin
                        o_cmd.adv8  = 1'b1;
                        n_out_valid = 1'b1;
                    end else if (!i_stat.len_ok) begin
                        n_out_valid = 1'b1;
                    end else begin
                        o_cmd.load_state = 1'b1;
                        n_cnt            = CW'(WARMUP_ROUNDS);
                        n_out_valid      = 1'b0;
                        n_state          = ST_WARM;
                    end
                end
            end
            ST_WARM: begin
                // eight rounds a cycle, single rounds for any remainder
                if (big_step) begin
                    o_cmd.adv8 = 1'b1;
                    n_cnt      = r_cnt - CW'(ROUNDS_PER_CYCLE);
                end else begin
                    o_cmd.adv1 = 1'b1;
                    n_cnt      = r_cnt - CW'(1);
                end
                if (n_cnt == '0) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

endmodule

// File: design/trivium_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// trivium_stream_cipher_top
// Trivium stream cipher, 80-bit key and IV, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration channel (i_cfg_valid/o_cfg_ready, index and 64-bit data)
//   sets key, IV and declared lengths; write it only while the block is idle.
//   Input channel (i_in_valid/o_in_stall) carries op, data byte, message end.
//   Output channel (o_out_valid/i_out_stall) returns one result per item.
// Latency and throughput:
//   A crypt item runs eight unrolled rounds in the cycle it is taken; its
//   result appears the next cycle, and crypt items sustain one per cycle
//   while the output is not stalled. A start item loads the state in its
//   accept cycle, then the warm-up runs eight rounds per cycle (single
//   rounds for a remainder). The result follows the last warm-up cycle.
//   A start with a bad key or IV length returns status 1 the next cycle
//   and leaves the state alone.
// Reset: lengths set to 10, other registers cleared but the result payload.
// Stall: while the result register is full and stalled, o_in_stall is high;
//   the result holds until taken. o_in_stall is also high during warm-up.
// ----------------------------------------------------------------------------
module trivium_stream_cipher_top
    import trv_pkg::*;
#(
    parameter int WARMUP_ROUNDS = 1152
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_trv_cmd  cmd;
    t_trv_stat stat;
    logic      cfg_we;

    // Configuration writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    trv_ctrl #(
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.op),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    trv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule
